@@ rtl/dtm_pkg.sv @@
// Package for the deadline timer manager: opcodes, states, widths.
package dtm_pkg;
  localparam int TimerSlotsDef = 16;
  localparam int IdW = 4;
  localparam int TimeW = 64;
  localparam int PerW = 32;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_TICK    = 3'd4,
    OP_COLLECT = 3'd5,
    OP_QUERY   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_FSCAN_RD,
    ST_FSCAN,
    ST_FDONE,
    ST_CSCAN_RD,
    ST_CSCAN,
    ST_CPICK_RD,
    ST_CPICK,
    ST_COUT,
    ST_CEND,
    ST_PEND,
    ST_OUT
  } state_t;
endpackage

@@ rtl/deadline_timer_manager.sv @@
// Deadline timer manager top level: slot tables, sequencer and shared compare unit.
// Add, reset and query may scan every slot for the earliest deadline, each slot read and then
// compared; collect rescans all slots once per expired timer it picks and once more to find
// none left, sending one word per pick; in_tready low while busy or a result waits.
// Reset (synchronous, rst_n low) clears time, active, queued and wake flag;
// deadline, period and repeat tables hold undefined contents until written.
module deadline_timer_manager #(
  parameter int TIMER_SLOTS = dtm_pkg::TimerSlotsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // op[2:0], timer_id[6:3], period_ms[38:7], start_now[39]
  input  logic         in_tuser,   // repeat_req
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // slot_out[3:0], ok[4], remaining_ms[68:5], any_pending[69]
  output logic [1:0]   out_tuser,  // expired[0], front_wakeup[1]
  output logic         out_tlast
);
  import dtm_pkg::*;
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic [TimeW-1:0] dl_mem [TIMER_SLOTS];
  logic [PerW-1:0]  pr_mem [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] rep_r, act_r, act_nxt, que_r, que_nxt, done_r, done_nxt;
  logic [TIMER_SLOTS-1:0] rep_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic wake_r, wake_nxt;

  state_t st_r, st_nxt;
  op_t op_r, op_nxt;
  logic [IdW-1:0] id_r, id_nxt;
  logic [PerW-1:0] ms_r, ms_nxt;
  logic frm_r, frm_nxt, rq_r, rq_nxt, valid_id;

  logic [SW-1:0] idx_r, idx_nxt, best_r, best_nxt, raddr;
  logic have_r, have_nxt;
  logic [TimeW-1:0] bdl_r, bdl_nxt, rd_dl;
  logic [PerW-1:0] rd_pr;
  logic [SW-1:0] rd_idx_r;
  logic cnt_any_r, cnt_any_nxt;
  logic surv_r, surv_nxt;

  logic we;
  logic [SW-1:0] waddr;
  logic [TimeW-1:0] wdl;
  logic wpr_en;
  logic [PerW-1:0] wpr;

  logic [IdW-1:0] o_slot_r, o_slot_nxt;
  logic o_ok_r, o_ok_nxt, o_exp_r, o_exp_nxt, o_wake_r, o_wake_nxt, o_last_r, o_last_nxt;
  logic [TimeW-1:0] o_rem_r, o_rem_nxt;
  logic o_pend_r, o_pend_nxt;
  logic ov_r, ov_nxt;

  // shared compare unit: candidate earlier than best (ties go to lower index = first seen)
  logic cand_lt, dl_lt_now;
  assign cand_lt = !have_r || (rd_dl < bdl_r);
  assign dl_lt_now = rd_dl < now_r;

  always_ff @(posedge clk) begin
    if (we) dl_mem[waddr] <= wdl;
    if (wpr_en) pr_mem[waddr] <= wpr;
    rd_dl <= dl_mem[raddr];
    rd_pr <= pr_mem[raddr];
    rd_idx_r <= raddr;
  end

  assign valid_id = 32'(id_r) < 32'(TIMER_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; now_r <= '0; wake_r <= 1'b0; act_r <= '0; que_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; now_r <= now_nxt; wake_r <= wake_nxt; act_r <= act_nxt;
      que_r <= que_nxt; ov_r <= ov_nxt;
    end
    rep_r <= rep_nxt; done_r <= done_nxt; op_r <= op_nxt; id_r <= id_nxt; ms_r <= ms_nxt;
    frm_r <= frm_nxt; rq_r <= rq_nxt; idx_r <= idx_nxt; best_r <= best_nxt;
    have_r <= have_nxt; bdl_r <= bdl_nxt; cnt_any_r <= cnt_any_nxt; surv_r <= surv_nxt;
    o_slot_r <= o_slot_nxt; o_ok_r <= o_ok_nxt; o_exp_r <= o_exp_nxt; o_rem_r <= o_rem_nxt;
    o_pend_r <= o_pend_nxt; o_wake_r <= o_wake_nxt; o_last_r <= o_last_nxt;
  end

  logic last_idx;
  assign last_idx = idx_r == SW'(TIMER_SLOTS-1);
  logic [SW-1:0] sid;
  assign sid = SW'(id_r);

  always_comb begin
    st_nxt = st_r; now_nxt = now_r; wake_nxt = wake_r; act_nxt = act_r; que_nxt = que_r;
    rep_nxt = rep_r; done_nxt = done_r; op_nxt = op_r; id_nxt = id_r; ms_nxt = ms_r;
    frm_nxt = frm_r; rq_nxt = rq_r; idx_nxt = idx_r; best_nxt = best_r; have_nxt = have_r;
    bdl_nxt = bdl_r; cnt_any_nxt = cnt_any_r; ov_nxt = ov_r; surv_nxt = surv_r;
    o_slot_nxt = o_slot_r; o_ok_nxt = o_ok_r; o_exp_nxt = o_exp_r; o_rem_nxt = o_rem_r;
    o_pend_nxt = o_pend_r; o_wake_nxt = o_wake_r; o_last_nxt = o_last_r;
    we = 1'b0; wpr_en = 1'b0; waddr = sid; wdl = '0; wpr = ms_r; raddr = sid;
    in_tready = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt = op_t'(in_tdata[2:0]); id_nxt = in_tdata[6:3]; ms_nxt = in_tdata[38:7];
          frm_nxt = in_tdata[39]; rq_nxt = in_tuser;
          o_slot_nxt = in_tdata[6:3]; o_ok_nxt = 1'b0; o_exp_nxt = 1'b0; o_rem_nxt = '0;
          o_wake_nxt = 1'b0; o_last_nxt = 1'b1; cnt_any_nxt = 1'b0; done_nxt = '0;
          st_nxt = ST_RD;
        end
      end
      ST_RD: st_nxt = ST_EXEC;  // read slot id; rd_dl/rd_pr hold it in ST_EXEC
      ST_EXEC: begin
        st_nxt = ST_PEND;
        case (op_r)
          OP_ADD: if (valid_id) begin
            we = 1'b1; wpr_en = 1'b1; wdl = now_r + TimeW'(ms_r);
            rep_nxt[sid] = rq_r; act_nxt[sid] = 1'b1; que_nxt[sid] = 1'b1;
            o_ok_nxt = 1'b1; st_nxt = ST_FSCAN_RD;
          end
          OP_CANCEL: if (valid_id && act_r[sid]) begin
            act_nxt[sid] = 1'b0; que_nxt[sid] = 1'b0; o_ok_nxt = 1'b1;
          end
          OP_REFRESH: if (valid_id && act_r[sid] && que_r[sid]) begin
            we = 1'b1; wdl = now_r + TimeW'(rd_pr); o_ok_nxt = 1'b1;
          end
          OP_RESET: if (valid_id) begin
            if (rd_pr == ms_r && !frm_r) o_ok_nxt = 1'b1;
            else if (act_r[sid] && que_r[sid]) begin
              we = 1'b1; wpr_en = 1'b1;
              wdl = (frm_r ? now_r : rd_dl - TimeW'(rd_pr)) + TimeW'(ms_r);
              o_ok_nxt = 1'b1; st_nxt = ST_FSCAN_RD;
            end
          end
          OP_TICK: begin now_nxt = now_r + 1'b1; o_ok_nxt = 1'b1; end
          OP_COLLECT: st_nxt = ST_CSCAN_RD;
          OP_QUERY: begin wake_nxt = 1'b0; o_ok_nxt = 1'b1; st_nxt = ST_FSCAN_RD; end
          default: ;
        endcase
        idx_nxt = '0; have_nxt = 1'b0; surv_nxt = 1'b0;
      end
      ST_FSCAN_RD: begin raddr = idx_r; st_nxt = ST_FSCAN; end
      ST_FSCAN: begin
        if (que_r[rd_idx_r] && cand_lt) begin
          have_nxt = 1'b1; best_nxt = rd_idx_r; bdl_nxt = rd_dl;
        end
        if (last_idx) st_nxt = ST_FDONE;
        else begin idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1; st_nxt = ST_FSCAN; end
        if (!last_idx) st_nxt = ST_FSCAN_RD;
      end
      ST_FDONE: begin
        if (op_r == OP_QUERY) begin
          if (!have_r) o_rem_nxt = '1;
          else if (bdl_r <= now_r) o_rem_nxt = '0;
          else o_rem_nxt = bdl_r - now_r;
        end else if (have_r && best_r == sid && !wake_r) begin
          wake_nxt = 1'b1; o_wake_nxt = 1'b1;
        end
        st_nxt = ST_PEND;
      end
      ST_CSCAN_RD: begin raddr = idx_r; st_nxt = ST_CSCAN; end
      ST_CSCAN: begin
        if (que_r[rd_idx_r] && !done_r[rd_idx_r] && dl_lt_now && cand_lt) begin
          have_nxt = 1'b1; best_nxt = rd_idx_r; bdl_nxt = rd_dl;
        end
        // slot still queued once the whole collect is over
        surv_nxt = surv_r | (que_r[rd_idx_r] &&
                             !(!done_r[rd_idx_r] && dl_lt_now && !rep_r[rd_idx_r]));
        if (last_idx) st_nxt = ST_CPICK_RD;
        else begin idx_nxt = idx_r + 1'b1; st_nxt = ST_CSCAN_RD; end
      end
      ST_CPICK_RD: begin
        raddr = best_r;
        if (!have_r) begin
          st_nxt = cnt_any_r ? ST_CEND : ST_PEND;
          if (!cnt_any_r) o_ok_nxt = 1'b1;
        end else if (cnt_any_r) begin
          // held word is not the last one: send it before the next pick
          o_pend_nxt = surv_r; ov_nxt = 1'b1; st_nxt = ST_COUT;
        end else st_nxt = ST_CPICK;
      end
      ST_COUT: begin
        raddr = best_r;
        if (out_tready) begin ov_nxt = 1'b0; cnt_any_nxt = 1'b0; st_nxt = ST_CPICK; end
      end
      ST_CPICK: begin
        done_nxt[best_r] = 1'b1;
        waddr = best_r;
        if (rep_r[best_r]) begin we = 1'b1; wdl = now_r + TimeW'(rd_pr); end
        else begin que_nxt[best_r] = 1'b0; act_nxt[best_r] = 1'b0; end
        o_slot_nxt = IdW'(best_r); o_ok_nxt = 1'b1; o_exp_nxt = 1'b1; o_last_nxt = 1'b0;
        o_pend_nxt = |que_nxt; cnt_any_nxt = 1'b1;
        idx_nxt = '0; have_nxt = 1'b0; surv_nxt = 1'b0;
        st_nxt = ST_CSCAN_RD;
      end
      ST_CEND: begin o_last_nxt = 1'b1; o_pend_nxt = |que_r; ov_nxt = 1'b1; st_nxt = ST_OUT; end
      ST_PEND: begin o_pend_nxt = |que_r; ov_nxt = 1'b1; st_nxt = ST_OUT; end
      ST_OUT: begin
        if (out_tready) begin ov_nxt = 1'b0; st_nxt = ST_IDLE; end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {2'b00, o_pend_r, o_rem_r, o_ok_r, o_slot_r};
  assign out_tuser = {o_wake_r, o_exp_r};
  assign out_tlast = o_last_r;
endmodule
